// File: rtl/core/brle_pkg.sv
// ----------------------------------------------------------------------------
// brle_pkg: shared types and constants of the bitmask RLE tile encoder
// Group size, byte type, the group record that moves through the queue, and
// the queue status struct.
// ----------------------------------------------------------------------------
package brle_pkg;

  localparam int GROUP_LEN   = 8;
  localparam int BYTE_W      = 8;
  localparam int IDX_W       = 3;   // index into one group
  localparam int CNT_W       = 4;   // occurrence count, 0..GROUP_LEN
  localparam int QUEUE_DEPTH = 2;

  typedef logic [BYTE_W-1:0] byte_t;

  // One complete group: the raw bytes in arrival order plus its fill byte.
  typedef struct packed {
    byte_t [GROUP_LEN-1:0] bytes;
    byte_t                 fill;
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/core/brle_in_if.sv
// ----------------------------------------------------------------------------
// brle_in_if: raw byte channel
// Valid/ready channel carrying one raw byte and the end-of-block flag.
// ----------------------------------------------------------------------------
interface brle_in_if import brle_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t byte_in;
  logic  last_in;

  modport source (output valid, output byte_in, output last_in, input ready);
  modport sink   (input valid, input byte_in, input last_in, output ready);
endinterface

// File: rtl/core/brle_out_if.sv
// ----------------------------------------------------------------------------
// brle_out_if: encoded byte channel
// Valid/ready channel carrying one encoded byte and the end-of-group flag.
// ----------------------------------------------------------------------------
interface brle_out_if import brle_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// File: rtl/core/brle_front.sv
// ----------------------------------------------------------------------------
// brle_front: group collector
// Collects raw bytes into groups of eight and tracks the running fill byte
// (most frequent value, earliest to reach the top count) one byte at a time.
// ----------------------------------------------------------------------------
module brle_front import brle_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  brle_in_if.sink raw,
  input  q_stat_t q_stat,
  output logic    q_push,
  output group_t  q_data
);

  logic [IDX_W-1:0] pos;
  byte_t            store [GROUP_LEN-1];
  logic [CNT_W-1:0] top;
  byte_t            fill;

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] top_eff;
  logic             take;
  byte_t            fill_next;
  logic             last_pos;
  logic             acc;

  // occurrences of the new byte among this group's earlier bytes, plus itself
  always_comb begin
    cnt = CNT_W'(1);
    for (int k = 0; k < GROUP_LEN - 1; k++) begin
      if ((IDX_W'(k) < pos) && (store[k] == raw.byte_in)) begin
        cnt = cnt + CNT_W'(1);
      end
    end
  end

  assign top_eff   = (pos == '0) ? '0 : top;
  assign take      = cnt > top_eff;
  assign fill_next = take ? raw.byte_in : fill;
  assign last_pos  = pos == IDX_W'(GROUP_LEN - 1);

  assign raw.ready = !last_pos || !q_stat.full;
  assign acc       = raw.valid && raw.ready;
  assign q_push    = acc && last_pos;

  always_comb begin
    for (int k = 0; k < GROUP_LEN - 1; k++) begin
      q_data.bytes[k] = store[k];
    end
    q_data.bytes[GROUP_LEN-1] = raw.byte_in;
    q_data.fill               = fill_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (acc) begin
      if (last_pos || raw.last_in) begin
        pos <= '0;
      end else begin
        pos <= pos + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      if (!last_pos) begin
        store[pos] <= raw.byte_in;
      end
      top  <= take ? cnt : top_eff;
      fill <= fill_next;
    end
  end

endmodule

// File: rtl/core/brle_queue.sv
// ----------------------------------------------------------------------------
// brle_queue: group record FIFO
// Short FIFO of completed groups between collector and emitter.
// ----------------------------------------------------------------------------
module brle_queue import brle_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  group_t  wdata,
  input  logic    pop,
  output group_t  rdata,
  output q_stat_t stat
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  group_t          mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  function automatic logic [PtrW-1:0] wrap_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign rdata      = mem[rd_ptr];
  assign stat.full  = count == CntW'(Depth);
  assign stat.empty = count == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// File: rtl/core/brle_back.sv
// ----------------------------------------------------------------------------
// brle_back: group emitter
// Emits control byte, fill byte and literals of one group, one byte per
// cycle while the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module brle_back import brle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  group_t      q_data,
  input  q_stat_t     q_stat,
  output logic        q_pop,
  brle_out_if.source  enc
);

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_FILL = 3'b010,
    BK_LIT  = 3'b100
  } bk_state_t;

  bk_state_t             state;
  byte_t [GROUP_LEN-1:0] bytes;
  byte_t                 fill;
  logic [GROUP_LEN-1:0]  rem;     // literals still to send, MSB = first byte
  logic                  ov;
  byte_t                 ob;
  logic                  ol;

  logic                  advance;
  logic [GROUP_LEN-1:0]  head_mask;
  logic [IDX_W-1:0]      sel_bit;
  logic [IDX_W-1:0]      sel_byte;
  logic [GROUP_LEN-1:0]  rem_clr;

  assign advance = !ov || enc.ready;
  assign q_pop   = advance && (state == BK_IDLE) && !q_stat.empty;

  always_comb begin
    for (int j = 0; j < GROUP_LEN; j++) begin
      head_mask[GROUP_LEN-1-j] = q_data.bytes[j] != q_data.fill;
    end
  end

  // highest pending bit is the earliest literal
  always_comb begin
    sel_bit = '0;
    for (int j = 0; j < GROUP_LEN; j++) begin
      if (rem[j]) begin
        sel_bit = IDX_W'(j);
      end
    end
    sel_byte = IDX_W'(GROUP_LEN - 1) - sel_bit;
    rem_clr  = rem & ~(GROUP_LEN'(1) << sel_bit);
  end

  assign enc.valid    = ov;
  assign enc.out_byte = ob;
  assign enc.out_last = ol;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      ov    <= 1'b0;
    end else if (advance) begin
      unique case (state)
        BK_IDLE: begin
          if (!q_stat.empty) begin
            ov    <= 1'b1;
            ob    <= head_mask;
            ol    <= 1'b0;
            bytes <= q_data.bytes;
            fill  <= q_data.fill;
            rem   <= head_mask;
            state <= BK_FILL;
          end else begin
            ov <= 1'b0;
          end
        end
        BK_FILL: begin
          ov    <= 1'b1;
          ob    <= fill;
          ol    <= rem == '0;
          state <= (rem == '0) ? BK_IDLE : BK_LIT;
        end
        BK_LIT: begin
          ov    <= 1'b1;
          ob    <= bytes[sel_byte];
          ol    <= rem_clr == '0;
          rem   <= rem_clr;
          state <= (rem_clr == '0) ? BK_IDLE : BK_LIT;
        end
        default: begin
          ov    <= 1'b0;
          state <= BK_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/bitmask_rle_tile_encoder.sv
// ----------------------------------------------------------------------------
// bitmask_rle_tile_encoder: grouped bitmask run-length encoder
// Raw bytes in, per group of eight: control byte, fill byte, literals out.
// ----------------------------------------------------------------------------
// Flow: completing a group writes its record into the queue; a free
//   emitter then pops it and registers its control byte.
// Throughput: one raw byte per cycle in while the queue has room for a
//   completed group; one encoded byte per cycle out while the receiver is
//   ready. A group emits 2 + L bytes (L = literal count, 0..7), so for
//   literal-heavy groups the single output port of the emitter sets the rate.
// Reset: rst (synchronous) empties the open group, the queue and the output.
module bitmask_rle_tile_encoder import brle_pkg::*; #(
  parameter int QDepth = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  brle_in_if.sink    raw,
  brle_out_if.source enc
);

  // Front to queue: completed group records with their fill byte.
  logic    q_push;
  group_t  q_wdata;
  // Queue to back.
  logic    q_pop;
  group_t  q_rdata;
  q_stat_t q_stat;

  // Front: counts occurrences as bytes arrive, so the fill byte is known
  // the cycle the group completes. Stalls only on the group's last byte
  // when the queue is full; partial groups end on last_in and are dropped.
  brle_front u_front (
    .clk    (clk),
    .rst    (rst),
    .raw    (raw),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  // Decoupling queue: lets the collector keep filling the next group
  // while the emitter is still sending earlier ones.
  brle_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Back: builds the control mask while popping and registers it as the
  // control byte on the pop, then sends fill, then literals in order.
  brle_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_data (q_rdata),
    .q_stat (q_stat),
    .q_pop  (q_pop),
    .enc    (enc)
  );

`ifndef ASSERT_OFF
  // the collector never completes a group into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (!q_stat.full || q_pop))
    else $error("group pushed into full queue");

  // the emitter only pops a record that exists
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // a completed group leaves the queue non-empty on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (q_push && !q_pop) |=> !q_stat.empty)
    else $error("pushed group lost");
`endif

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: bench for the grouped bitmask RLE tile encoder
// Feeds raw bytes over the input channel with random gaps, backpressures the
// encoded channel, and checks every encoded transaction in order against a
// group-by-group prediction kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb;
  import brle_pkg::*;

  localparam byte_t CTRL_ALL_LIT = 8'hFF;  // control byte before any fill match
  localparam byte_t CTRL_TOP_BIT = 8'h80;  // control bit of the first group byte
  localparam int    RAW_ITEMS    = 470;
  localparam int    CALM_FROM    = 410;    // no idling on either side past this
  localparam int    DRAIN_CYCLES = 16;     // idle wait after the scoreboard drains

  // Tracks the open group and the encoded bytes still owed by the block.
  class encode_tracker;
    typedef struct packed {
      byte_t val;
      logic  tail;
    } enc_byte_t;

    enc_byte_t   due[$];
    byte_t       group [GROUP_LEN];
    int unsigned held;
    int unsigned errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    // One accepted raw byte: store it, encode on the eighth, drop on an
    // early end-of-block.
    function void take_raw(byte_t b, logic l);
      group[held] = b;
      if (held == GROUP_LEN - 1) begin
        held = 0;
        queue_encoding();
      end else if (l) begin
        held = 0;
      end else begin
        held++;
      end
    endfunction

    // Fill byte is the first value whose running count strictly beats the
    // best so far; ties keep the earlier winner.
    function void queue_encoding();
      byte_t     fill_b;
      byte_t     ctrl;
      int        top;
      int        cnt;
      enc_byte_t lits[$];
      fill_b = group[0];
      top    = 0;
      for (int j = 0; j < GROUP_LEN; j++) begin
        cnt = 0;
        for (int k = 0; k <= j; k++) begin
          if (group[k] == group[j]) cnt++;
        end
        if (cnt > top) begin
          top    = cnt;
          fill_b = group[j];
        end
      end
      ctrl = CTRL_ALL_LIT;
      for (int j = 0; j < GROUP_LEN; j++) begin
        if (group[j] == fill_b) ctrl = ctrl ^ (CTRL_TOP_BIT >> j);
        else lits.push_back('{val: group[j], tail: 1'b0});
      end
      due.push_back('{val: ctrl, tail: 1'b0});
      due.push_back('{val: fill_b, tail: (lits.size() == 0)});
      foreach (lits[i]) begin
        lits[i].tail = (i == lits.size() - 1);
        due.push_back(lits[i]);
      end
    endfunction

    // One encoded transaction against the oldest owed byte.
    function void match_encoded(byte_t b, logic l);
      enc_byte_t want;
      if (due.size() == 0) begin
        $display("%0t tb: unexpected out_byte %02h out_last %0b", $time, b, l);
        errors++;
        return;
      end
      want = due.pop_front();
      if (b !== want.val) begin
        $display("%0t tb: out_byte expected %02h actual %02h", $time, want.val, b);
        errors++;
      end
      if (l !== want.tail) begin
        $display("%0t tb: out_last expected %0b actual %0b", $time, want.tail, l);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   calm = 1'b0;
  int   sent = 0;

  encode_tracker tracker = new();

  brle_in_if  raw_ch ();
  brle_out_if enc_ch ();

  bitmask_rle_tile_encoder uut (
    .clk (clk),
    .rst (rst),
    .raw (raw_ch),
    .enc (enc_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs; far above the slowest legal run.
  initial begin
    #2000000;
    $display("tb: done, errors");
    $finish;
  end

  // Encoded side: random ready-low bursts, steady ready once calm.
  // Each pass assigns ready once, so no double update within one edge.
  initial begin
    enc_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (calm || $urandom_range(0, 5) != 0) begin
        enc_ch.ready <= 1'b1;
      end else begin
        enc_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // Values read here are the pre-edge ones, the same the block samples.
  always @(posedge clk) begin
    if (!rst && enc_ch.valid && enc_ch.ready) begin
      tracker.match_encoded(enc_ch.out_byte, enc_ch.out_last);
    end
  end

  // One raw transaction, optionally after an idle burst. valid stays high
  // from one transaction to the next when there is no gap.
  task automatic push_raw(input byte_t b, input logic l);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      raw_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    raw_ch.valid   <= 1'b1;
    raw_ch.byte_in <= b;
    raw_ch.last_in <= l;
    @(posedge clk);
    while (!raw_ch.ready) @(posedge clk);
    tracker.take_raw(b, l);
    sent++;
  endtask

  task automatic push_pattern(input byte_t pat [GROUP_LEN], input logic tail);
    for (int i = 0; i < GROUP_LEN; i++) push_raw(pat[i], tail && (i == GROUP_LEN - 1));
  endtask

  // Full group drawn from a small symbol set so fills and ties show up often.
  task automatic push_group(input int n_sym, input logic tail);
    byte_t sym [GROUP_LEN];
    for (int i = 0; i < n_sym; i++) sym[i] = byte_t'($urandom_range(0, 255));
    for (int i = 0; i < GROUP_LEN; i++) begin
      push_raw(sym[$urandom_range(0, n_sym - 1)], tail && (i == GROUP_LEN - 1));
    end
  endtask

  // Group cut short by end-of-block; nothing should come out of it.
  task automatic push_stub(input int len);
    for (int i = 0; i < len; i++) push_raw(byte_t'($urandom_range(0, 255)), i == len - 1);
  endtask

  initial begin
    byte_t pat [GROUP_LEN];
    int    pick;

    rst            <= 1'b1;
    raw_ch.valid   <= 1'b0;
    raw_ch.byte_in <= '0;
    raw_ch.last_in <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: all-fill group at the top byte value, no literals.
    pat = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    push_pattern(pat, 1'b0);
    // All distinct, field extremes, end-of-block landing on the eighth byte.
    pat = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE};
    push_pattern(pat, 1'b1);
    // Tie: 0x11 and 0x22 both reach two, 0x22 got there first.
    pat = '{8'h11, 8'h22, 8'h22, 8'h11, 8'h33, 8'h33, 8'h44, 8'h44};
    push_pattern(pat, 1'b0);
    // Partial group dropped by end-of-block.
    push_raw(8'h3C, 1'b0);
    push_raw(8'hC3, 1'b1);

    // Random: mostly whole groups, some stray bytes and cut groups.
    while (sent < RAW_ITEMS) begin
      if (sent >= CALM_FROM) calm = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        push_raw(byte_t'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else if (pick == 1) begin
        push_stub($urandom_range(1, 7));
      end else begin
        // realign on a group boundary before a clean group
        if (tracker.held != 0) push_raw(byte_t'($urandom_range(0, 255)), 1'b1);
        push_group($urandom_range(1, GROUP_LEN), $urandom_range(0, 2) == 0);
      end
    end
    raw_ch.valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/core/brle_pkg.sv
rtl/core/brle_in_if.sv
rtl/core/brle_out_if.sv
rtl/core/brle_front.sv
rtl/core/brle_queue.sv
rtl/core/brle_back.sv
rtl/core/bitmask_rle_tile_encoder.sv
bench/tb.sv
